// ----- rtl/tmd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the transport message deframer.
package tmd_pkg;

	localparam int MAX_MESSAGES     = 32;
	localparam int MAX_PACKET_BYTES = 2048;

	localparam int POS_W   = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CNT_W   = $clog2(MAX_MESSAGES + 1);
	localparam int TOTAL_W = 13;
	localparam int HDR_W   = 24;
	localparam int CMP_W   = ((POS_W > TOTAL_W) ? POS_W : TOTAL_W) + 1;
	localparam int DCMP_W  = ((CNT_W > 8) ? CNT_W : 8);

	localparam int IDX_W   = 5;
	localparam int OFF_W   = 11;
	localparam int PCNT_W  = 6;

	localparam logic [7:0] TYPE_ACK  = 8'h01;
	localparam logic [7:0] TYPE_GAME = 8'h32;
	localparam int RELIABLE_BIT = 7;

	localparam int ACK_TOTAL       = 4;
	localparam int GAME_HDR        = 3;
	localparam int GAME_REL_HDR    = 5;
	localparam int GENERIC_HDR     = 2;
	localparam int FIRST_MSG_START = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_HDR_CUT   = 3'd2,
		ERR_LEN_SMALL = 3'd3,
		ERR_OVERRUN   = 3'd4,
		ERR_OVERSIZE  = 3'd5
	} err_t;

	typedef enum logic {
		KIND_DESC   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   msg_index;
		logic [7:0]         msg_type;
		logic [15:0]        seq;
		logic [7:0]         flags;
		logic [OFF_W-1:0]   payload_offset;
		logic [OFF_W-1:0]   payload_size;
		logic [7:0]         direction;
		logic [PCNT_W-1:0]  parsed_count;
		err_t               error_code;
		logic               last;
	} res_t;

	typedef struct packed {
		logic desc_valid;
		logic status_valid;
		res_t desc;
		res_t status;
	} push_t;

endpackage

// ----- rtl/tmd_frame_if.sv -----
`timescale 1ns / 1ps
// Byte channel carrying the received packet.
interface tmd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/tmd_result_if.sv -----
`timescale 1ns / 1ps
// Result channel carrying message descriptors and packet status.
interface tmd_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [4:0]  msg_index;
	logic [7:0]  msg_type;
	logic [15:0] seq;
	logic [7:0]  flags;
	logic [10:0] payload_offset;
	logic [10:0] payload_size;
	logic [7:0]  direction;
	logic [5:0]  parsed_count;
	logic [2:0]  error_code;
	logic        last;

	modport source (
		output valid, output kind, output msg_index, output msg_type, output seq,
		output flags, output payload_offset, output payload_size, output direction,
		output parsed_count, output error_code, output last, input ready
	);
	modport sink (
		input valid, input kind, input msg_index, input msg_type, input seq,
		input flags, input payload_offset, input payload_size, input direction,
		input parsed_count, input error_code, input last, output ready
	);
endinterface

// ----- rtl/tmd_parser.sv -----
`timescale 1ns / 1ps
// Packet parse state and the per-byte message splitting logic.
module tmd_parser
	import tmd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output push_t      push
);

	logic [POS_W-1:0]   pos_q, n_pos;
	logic [7:0]         dir_q, n_dir;
	logic [7:0]         decl_q, n_decl;
	logic [CNT_W-1:0]   cnt_q, n_cnt;
	logic [POS_W-1:0]   mstart_q, n_mstart;
	logic [7:0]         ctype_q, n_ctype;
	logic [HDR_W-1:0]   hdr_q, n_hdr;
	logic [TOTAL_W-1:0] total_q, n_total;
	err_t               err_q, n_err;
	logic               done_q, n_done;
	logic               small_q, n_small;

	res_t desc, status;
	logic desc_v;

	always_comb begin
		logic [POS_W-1:0] off;
		logic             complete;
		logic             hit_end;
		logic [POS_W-1:0] hdr_len;

		n_pos    = pos_q;
		n_dir    = dir_q;
		n_decl   = decl_q;
		n_cnt    = cnt_q;
		n_mstart = mstart_q;
		n_ctype  = ctype_q;
		n_hdr    = hdr_q;
		n_total  = total_q;
		n_err    = err_q;
		n_done   = done_q;
		n_small  = small_q;
		complete = 1'b0;
		hit_end  = 1'b0;
		hdr_len  = '0;
		desc_v   = 1'b0;
		desc     = '0;
		status   = '0;
		off      = pos_q - mstart_q;

		if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
			n_pos = pos_q + POS_W'(1);
		end

		if (pos_q >= POS_W'(MAX_PACKET_BYTES)) begin
			n_err  = ERR_OVERSIZE;
			n_done = 1'b1;
		end else if (!done_q) begin
			if (pos_q == '0) begin
				n_dir = data_byte;
			end else if (pos_q == POS_W'(1)) begin
				n_decl   = data_byte;
				n_mstart = POS_W'(FIRST_MSG_START);
				if (data_byte == 8'h00) begin
					n_done = 1'b1;
				end
			end else begin
				if (off == '0) begin
					n_ctype = data_byte;
					n_hdr   = '0;
					n_total = (data_byte == TYPE_ACK) ? TOTAL_W'(ACK_TOTAL) : '0;
					n_small = 1'b0;
				end else if (ctype_q == TYPE_ACK) begin
					if (off == POS_W'(1)) begin
						n_hdr = {16'h0000, data_byte};
					end else if (off == POS_W'(3)) begin
						n_hdr    = {data_byte, hdr_q[15:0]};
						complete = 1'b1;
					end
				end else if (ctype_q == TYPE_GAME) begin
					if (off == POS_W'(1)) begin
						n_hdr = {16'h0000, data_byte};
					end else if (off == POS_W'(2)) begin
						n_total = {data_byte[4:0], hdr_q[7:0]};
						n_hdr   = {data_byte, 16'h0000};
						if (n_total < TOTAL_W'(GAME_HDR)) begin
							n_err  = ERR_LEN_SMALL;
							n_done = 1'b1;
						end else if (data_byte[RELIABLE_BIT] &&
						             n_total < TOTAL_W'(GAME_REL_HDR)) begin
							n_small = 1'b1;
						end
					end else if (off == POS_W'(3)) begin
						n_hdr = {hdr_q[23:16], data_byte, hdr_q[7:0]};
					end else if (off == POS_W'(4)) begin
						n_hdr = {hdr_q[23:8], data_byte};
					end
					if (!n_done && off >= POS_W'(2) &&
					    CMP_W'(off) + CMP_W'(1) == CMP_W'(n_total)) begin
						complete = 1'b1;
					end
				end else begin
					if (off == POS_W'(1)) begin
						n_total = {5'h00, data_byte};
						if (data_byte < 8'd2) begin
							n_err  = ERR_LEN_SMALL;
							n_done = 1'b1;
						end
					end
					if (!n_done && off >= POS_W'(1) &&
					    CMP_W'(off) + CMP_W'(1) == CMP_W'(n_total)) begin
						complete = 1'b1;
					end
				end
			end
		end

		if (complete) begin
			if (n_small) begin
				n_err  = ERR_LEN_SMALL;
				n_done = 1'b1;
			end else begin
				desc_v         = 1'b1;
				desc.kind      = KIND_DESC;
				desc.msg_index = cnt_q[IDX_W-1:0];
				desc.msg_type  = n_ctype;
				desc.direction = n_dir;
				desc.last      = !last_byte;
				if (n_ctype == TYPE_ACK) begin
					desc.seq   = {8'h00, n_hdr[7:0]};
					desc.flags = n_hdr[23:16];
				end else begin
					if (n_ctype == TYPE_GAME) begin
						desc.flags = n_hdr[23:16];
						if (n_hdr[16 + RELIABLE_BIT]) begin
							desc.seq = n_hdr[15:0];
							hdr_len  = POS_W'(GAME_REL_HDR);
						end else begin
							hdr_len  = POS_W'(GAME_HDR);
						end
					end else begin
						hdr_len = POS_W'(GENERIC_HDR);
					end
					desc.payload_offset = OFF_W'(mstart_q + hdr_len);
					desc.payload_size   = OFF_W'(n_total - TOTAL_W'(hdr_len));
				end
				n_cnt    = cnt_q + CNT_W'(1);
				n_mstart = pos_q + POS_W'(1);
				if (DCMP_W'(n_cnt) >= DCMP_W'(decl_q) ||
				    n_cnt >= CNT_W'(MAX_MESSAGES)) begin
					n_done = 1'b1;
				end
			end
		end

		if (last_byte) begin
			if (n_err != ERR_OVERSIZE) begin
				if (pos_q == '0) begin
					n_err = ERR_SHORT;
				end else if (!n_done && pos_q >= POS_W'(2) && pos_q >= n_mstart) begin
					hit_end = 1'b1;
				end
			end
			if (hit_end) begin
				if (n_ctype == TYPE_ACK) begin
					n_err = ERR_HDR_CUT;
				end else if (n_ctype == TYPE_GAME) begin
					n_err = (off < POS_W'(2)) ? ERR_HDR_CUT : ERR_OVERRUN;
				end else begin
					n_err = (off < POS_W'(1)) ? ERR_HDR_CUT : ERR_OVERRUN;
				end
			end
			status.kind         = KIND_STATUS;
			status.direction    = n_dir;
			status.parsed_count = PCNT_W'(n_cnt);
			status.error_code   = n_err;
			status.last         = 1'b1;

			n_pos    = '0;
			n_dir    = '0;
			n_decl   = '0;
			n_cnt    = '0;
			n_mstart = '0;
			n_ctype  = '0;
			n_hdr    = '0;
			n_total  = '0;
			n_err    = ERR_OK;
			n_done   = 1'b0;
			n_small  = 1'b0;
		end
	end

	always_comb begin
		push.desc_valid   = accept & desc_v;
		push.status_valid = accept & last_byte;
		push.desc         = desc;
		push.status       = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			dir_q    <= '0;
			decl_q   <= '0;
			cnt_q    <= '0;
			mstart_q <= '0;
			ctype_q  <= '0;
			hdr_q    <= '0;
			total_q  <= '0;
			err_q    <= ERR_OK;
			done_q   <= 1'b0;
			small_q  <= 1'b0;
		end else if (accept) begin
			pos_q    <= n_pos;
			dir_q    <= n_dir;
			decl_q   <= n_decl;
			cnt_q    <= n_cnt;
			mstart_q <= n_mstart;
			ctype_q  <= n_ctype;
			hdr_q    <= n_hdr;
			total_q  <= n_total;
			err_q    <= n_err;
			done_q   <= n_done;
			small_q  <= n_small;
		end
	end

`ifndef SYNTH
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> pos_q == '0 && cnt_q == '0 && !done_q)
		else $error("packet state not cleared after packet end");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_PACKET_BYTES))
		else $error("byte position beyond saturation point");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_MESSAGES))
		else $error("message count beyond limit");
`endif

endmodule

// ----- rtl/tmd_fifo.sv -----
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, gives at most one.
module tmd_fifo
	import tmd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output res_t  head,
	output logic  not_empty,
	output logic  room2
);

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] count_q;
	logic [FIFO_CW-1:0] n_push;
	logic [FIFO_AW-1:0] stat_addr;

	assign n_push    = FIFO_CW'(push.desc_valid) + FIFO_CW'(push.status_valid);
	assign stat_addr = push.desc_valid ? wr_q + FIFO_AW'(1) : wr_q;
	assign head      = mem[rd_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.desc_valid) begin
			mem[wr_q] <= push.desc;
		end
		if (push.status_valid) begin
			mem[stat_addr] <= push.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(n_push);
			rd_q    <= rd_q + FIFO_AW'(pop);
			count_q <= count_q + n_push - FIFO_CW'(pop);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		n_push != '0 |-> (count_q + n_push) <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue written without room");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue read while empty");
`endif

endmodule

// ----- rtl/transport_message_deframer.sv -----
`timescale 1ns / 1ps
// Top level of the transport message deframer.
// Takes one packet byte per cycle on frame and splits the packet into transport messages,
// giving one descriptor on result for each completed message and one status item on the
// byte marked last. A byte produces zero, one or two results, which are written into the
// result queue as the byte is taken. Results pass through a four-entry queue that drains
// one a cycle while result.ready is high; frame.ready is high while the queue has room
// for two, so a packet streams at one byte per cycle as long as the result side keeps up.
// Parse state returns to its reset value after each status item.
module transport_message_deframer
	import tmd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tmd_frame_if.sink    frame,
	tmd_result_if.source result
);

	push_t push;
	res_t  head;
	logic  accept;
	logic  pop;
	logic  not_empty;
	logic  room2;

	assign frame.ready = room2;
	assign accept      = frame.valid & frame.ready;
	assign pop         = result.valid & result.ready;

	tmd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (frame.data_byte),
		.last_byte (frame.last_byte),
		.push      (push)
	);

	tmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign result.valid          = not_empty;
	assign result.kind           = head.kind;
	assign result.msg_index      = head.msg_index;
	assign result.msg_type       = head.msg_type;
	assign result.seq            = head.seq;
	assign result.flags          = head.flags;
	assign result.payload_offset = head.payload_offset;
	assign result.payload_size   = head.payload_size;
	assign result.direction      = head.direction;
	assign result.parsed_count   = head.parsed_count;
	assign result.error_code     = head.error_code;
	assign result.last           = head.last;

endmodule
